// ===== sv/fspk_pkg.sv =====
// Shared types and constants for the FFT spectrum peak finder.
// Used by the root cells, the sample-rate divider and the top level.
package fspk_pkg;

	localparam int unsigned CLOCK_HZ = 84000000;

	localparam int RELOAD_W   = 16;
	localparam int PRESCALE_W = 8;
	localparam int CFG_W      = 16;
	localparam int REG_IDX_W  = 1;

	localparam int SMP_W      = 16;
	localparam int MAG_W      = 16;
	localparam int BIN_W      = 9;
	localparam int FREQ_W     = 26;
	localparam int POW_W      = 32;
	localparam int FS_W       = 27;
	localparam int ROOT_STEPS = 16;

	localparam logic [RELOAD_W-1:0]   RELOAD_RESET   = 16'd1680;
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd1;
	localparam logic [FS_W-1:0]       FS_RESET       =
		FS_W'(CLOCK_HZ / int'(RELOAD_RESET) / int'(PRESCALE_RESET));

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_TIMER_RELOAD   = 1'b0;
	localparam reg_idx_t REG_TIMER_PRESCALE = 1'b1;

	typedef logic [POW_W-1:0] pow_t;

	// Result fields that ride along the root chain untouched.
	typedef struct packed {
		logic [BIN_W-1:0]  bin_number;
		logic              frame_done;
		logic [BIN_W-1:0]  peak_bin;
		logic [FREQ_W-1:0] peak_freq;
	} side_t;

endpackage

// ===== sv/fft_spectrum_peak_finder.sv =====
// FFT spectrum peak finder: per-bin magnitude and peak-frequency search.
// Depends on fspk_pkg, fspk_rate_div and fspk_sqrt_cell.
//
// Usage:
// Bins 1 to FFT_POINTS/2-1 enter in order on the input channel, one per
// transfer. Every input transfer yields exactly one output transfer carrying
// the floor square root of the bin's power and its bin number. On the last
// bin of the frame, frame_done is set and peak_bin/peak_freq give the first
// bin of strictly greatest power and its frequency in hertz.
// Five front stages (magnitude, squares, sum, peak tracking, frequency
// multiply) feed a chain of 16 root cells. A bin can be taken every cycle
// unless a rate recompute is pending or the pipeline is full and stalled.
// Every stage only holds its item while the one after it is full and
// stalled, so the input takes bins into empty stages while the output waits.
// A configuration write restarts the sample-rate divider, which produces one
// quotient bit per cycle; input is held off until the new rate is ready.
// Reset empties the pipeline, restarts the frame at bin 1 and loads the
// reset sample rate of 50 kHz with no division pass. FFT_POINTS must be a
// power of two.
module fft_spectrum_peak_finder #(
	parameter int FFT_POINTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [fspk_pkg::SMP_W-1:0] bin_real,
	input  logic signed [fspk_pkg::SMP_W-1:0] bin_imag,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fspk_pkg::MAG_W-1:0]       magnitude,
	output logic [fspk_pkg::BIN_W-1:0]       bin_number,
	output logic                             frame_done,
	output logic [fspk_pkg::BIN_W-1:0]       peak_bin,
	output logic [fspk_pkg::FREQ_W-1:0]      peak_freq,
	input  logic                             cfg_we,
	input  fspk_pkg::reg_idx_t               cfg_index,
	input  logic [fspk_pkg::CFG_W-1:0]       cfg_data
);
	import fspk_pkg::*;

	localparam int LAST   = FFT_POINTS / 2 - 1;
	localparam int CNT_W  = $clog2(FFT_POINTS / 2);
	localparam int LOG2N  = $clog2(FFT_POINTS);
	localparam int EXT_W  = (CNT_W > BIN_W) ? CNT_W : BIN_W;
	localparam int PROD_W = CNT_W + FS_W;
	localparam logic [CNT_W-1:0] LAST_BIN  = CNT_W'(LAST);
	localparam logic [CNT_W-1:0] FIRST_BIN = CNT_W'(1);
	localparam logic [EXT_W-1:0] LAST_EXT  = EXT_W'(LAST);
	localparam logic [BIN_W-1:0] LAST_NUM  = LAST_EXT[BIN_W-1:0];

	// Configuration and sample rate
	logic [RELOAD_W-1:0]   reload_q;
	logic [PRESCALE_W-1:0] prescale_q;
	logic                  pend_q;
	logic                  div_busy;
	logic [FS_W-1:0]       fs_rate;
	logic [RELOAD_W-1:0]   reload_eff;
	logic [PRESCALE_W-1:0] prescale_eff;

	// Front stages
	logic                  in_fire;
	logic [CNT_W-1:0]      cnt_q;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                  ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;
	logic [SMP_W-1:0]      are_s1, aim_s1;
	logic [CNT_W-1:0]      bin_s1, bin_s2, bin_s3, bin_s4;
	logic                  first_s1, first_s2, first_s3;
	logic                  done_s1, done_s2, done_s3, done_s4;
	pow_t                  sqre_s2, sqim_s2;
	pow_t                  pow_s3, pow_s4, pow_s5;
	logic [CNT_W-1:0]      peak_s4;
	side_t                 side_s5;

	// Peak tracking
	pow_t                  best_pow_q;
	logic [CNT_W-1:0]      best_bin_q;
	pow_t                  cmp_pow;
	logic [CNT_W-1:0]      cmp_bin;
	logic                  better;
	pow_t                  new_pow;
	logic [CNT_W-1:0]      new_bin;

	// Frequency stage
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-1:0]     prod_shr;
	logic [EXT_W-1:0]      num_ext;
	logic [EXT_W-1:0]      peak_ext;
	side_t                 side_n;

	// Root chain
	logic [ROOT_STEPS:0]   ch_valid;
	logic [ROOT_STEPS:0]   ch_ready;
	pow_t                  ch_rem  [0:ROOT_STEPS];
	pow_t                  ch_root [0:ROOT_STEPS];
	side_t                 ch_side [0:ROOT_STEPS];

	// ---------------------------------------------------------------
	// Configuration registers and rate divider
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= RELOAD_RESET;
			prescale_q <= PRESCALE_RESET;
			pend_q     <= 1'b0;
		end else begin
			pend_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMER_RELOAD:   reload_q   <= cfg_data[RELOAD_W-1:0];
					REG_TIMER_PRESCALE: prescale_q <= cfg_data[PRESCALE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// A zero divisor is treated as one.
	assign reload_eff   = (reload_q == '0) ? RELOAD_W'(1) : reload_q;
	assign prescale_eff = (prescale_q == '0) ? PRESCALE_W'(1) : prescale_q;

	fspk_rate_div u_rate_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pend_q),
		.reload   (reload_eff),
		.prescale (prescale_eff),
		.busy     (div_busy),
		.rate     (fs_rate)
	);

	// ---------------------------------------------------------------
	// Handshake chain
	// ---------------------------------------------------------------
	assign ready_s5 = !v_s5 || ch_ready[0];
	assign ready_s4 = !v_s4 || ready_s5;
	assign ready_s3 = !v_s3 || ready_s4;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1 && !pend_q && !div_busy;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= FIRST_BIN;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			if (in_fire) begin
				cnt_q <= (cnt_q >= LAST_BIN) ? FIRST_BIN : cnt_q + CNT_W'(1);
			end
			if (ready_s1) v_s1 <= in_fire;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
			if (ready_s4) v_s4 <= v_s3;
			if (ready_s5) v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: absolute values. The most negative sample maps to 32768,
	// which still fits the unsigned width.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			are_s1   <= bin_real[SMP_W-1] ? SMP_W'(-bin_real) : SMP_W'(bin_real);
			aim_s1   <= bin_imag[SMP_W-1] ? SMP_W'(-bin_imag) : SMP_W'(bin_imag);
			bin_s1   <= cnt_q;
			first_s1 <= (cnt_q == FIRST_BIN);
			done_s1  <= (cnt_q >= LAST_BIN);
		end
	end

	// Stage 2: squares
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			sqre_s2  <= POW_W'(are_s1) * POW_W'(are_s1);
			sqim_s2  <= POW_W'(aim_s1) * POW_W'(aim_s1);
			bin_s2   <= bin_s1;
			first_s2 <= first_s1;
			done_s2  <= done_s1;
		end
	end

	// Stage 3: power, at most 2^31
	always_ff @(posedge clk) begin
		if (v_s2 && ready_s3) begin
			pow_s3   <= sqre_s2 + sqim_s2;
			bin_s3   <= bin_s2;
			first_s3 <= first_s2;
			done_s3  <= done_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: peak tracking. The first bin of a frame is judged against
	// zero; an equal power later in the frame does not replace the peak.
	// ---------------------------------------------------------------
	always_comb begin
		cmp_pow = first_s3 ? '0 : best_pow_q;
		cmp_bin = first_s3 ? '0 : best_bin_q;
		better  = pow_s3 > cmp_pow;
		new_pow = better ? pow_s3 : cmp_pow;
		new_bin = better ? bin_s3 : cmp_bin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_pow_q <= '0;
			best_bin_q <= '0;
		end else if (v_s3 && ready_s4) begin
			best_pow_q <= new_pow;
			best_bin_q <= new_bin;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && ready_s4) begin
			pow_s4  <= pow_s3;
			bin_s4  <= bin_s3;
			done_s4 <= done_s3;
			peak_s4 <= new_bin;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: peak frequency = peak * fs / FFT_POINTS
	// ---------------------------------------------------------------
	always_comb begin
		prod     = PROD_W'(peak_s4) * PROD_W'(fs_rate);
		prod_shr = prod >> LOG2N;
		num_ext  = EXT_W'(bin_s4);
		peak_ext = EXT_W'(peak_s4);
		side_n.bin_number = num_ext[BIN_W-1:0];
		side_n.frame_done = done_s4;
		side_n.peak_bin   = done_s4 ? peak_ext[BIN_W-1:0] : '0;
		side_n.peak_freq  = done_s4 ? FREQ_W'(prod_shr) : '0;
	end

	always_ff @(posedge clk) begin
		if (v_s4 && ready_s5) begin
			pow_s5  <= pow_s4;
			side_s5 <= side_n;
		end
	end

	// ---------------------------------------------------------------
	// Square-root chain
	// ---------------------------------------------------------------
	assign ch_valid[0] = v_s5;
	assign ch_rem[0]   = pow_s5;
	assign ch_root[0]  = '0;
	assign ch_side[0]  = side_s5;
	assign ch_ready[ROOT_STEPS] = out_ready;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		fspk_sqrt_cell #(
			.STEP (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[k]),
			.up_ready (ch_ready[k]),
			.up_rem   (ch_rem[k]),
			.up_root  (ch_root[k]),
			.up_side  (ch_side[k]),
			.dn_valid (ch_valid[k+1]),
			.dn_ready (ch_ready[k+1]),
			.dn_rem   (ch_rem[k+1]),
			.dn_root  (ch_root[k+1]),
			.dn_side  (ch_side[k+1])
		);
	end

	assign out_valid  = ch_valid[ROOT_STEPS];
	assign magnitude  = ch_root[ROOT_STEPS][MAG_W-1:0];
	assign bin_number = ch_side[ROOT_STEPS].bin_number;
	assign frame_done = ch_side[ROOT_STEPS].frame_done;
	assign peak_bin   = ch_side[ROOT_STEPS].peak_bin;
	assign peak_freq  = ch_side[ROOT_STEPS].peak_freq;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_peak_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> peak_bin == '0 && peak_freq == '0)
		else $error("peak fields set on a bin that does not end the frame");

	a_done_on_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> bin_number == LAST_NUM)
		else $error("frame end flagged on a bin other than the last");

	a_hold_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken before the sample rate was recomputed");

endmodule

// ===== sv/fspk_sqrt_cell.sv =====
// One cell of the square-root chain: settles one result bit per cell.
// Depends on fspk_pkg for the power and side-payload types.
module fspk_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  fspk_pkg::pow_t up_rem,
	input  fspk_pkg::pow_t up_root,
	input  fspk_pkg::side_t up_side,
	output logic           dn_valid,
	input  logic           dn_ready,
	output fspk_pkg::pow_t dn_rem,
	output fspk_pkg::pow_t dn_root,
	output fspk_pkg::side_t dn_side
);
	import fspk_pkg::*;

	localparam pow_t BIT = POW_W'(1) << (POW_W - 2 - 2 * STEP);

	logic         valid_q;
	pow_t         rem_q;
	pow_t         root_q;
	side_t        side_q;
	logic [POW_W:0] trial;
	logic         take;
	pow_t         rem_n;
	pow_t         root_n;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		trial  = {1'b0, up_root} + {1'b0, BIT};
		take   = {1'b0, up_rem} >= trial;
		rem_n  = take ? up_rem - trial[POW_W-1:0] : up_rem;
		root_n = take ? (up_root >> 1) + BIT : (up_root >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			rem_q  <= rem_n;
			root_q <= root_n;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_root  = root_q;
	assign dn_side  = side_q;

endmodule

// ===== sv/fspk_rate_div.sv =====
// Sample-rate divider: 84 MHz over reload times prescale, one quotient bit a cycle.
// Depends on fspk_pkg for the register widths and the reset rate.
module fspk_rate_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fspk_pkg::RELOAD_W-1:0]   reload,
	input  logic [fspk_pkg::PRESCALE_W-1:0] prescale,
	output logic                            busy,
	output logic [fspk_pkg::FS_W-1:0]       rate
);
	import fspk_pkg::*;

	localparam int DVS_W = RELOAD_W + PRESCALE_W;
	localparam int CNT_W = $clog2(FS_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FS_W - 1);
	localparam logic [FS_W-1:0]  DIVIDEND  = FS_W'(CLOCK_HZ);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [FS_W-1:0]  quo_q;
	logic [FS_W-1:0]  rate_q;
	logic [DVS_W:0]   shifted;
	logic             fits;
	logic [DVS_W-1:0] rem_n;

	// The partial remainder always stays below the divisor, so it fits DVS_W bits.
	always_comb begin
		shifted = {rem_q, quo_q[FS_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		rem_n   = fits ? DVS_W'(shifted - {1'b0, dvs_q}) : DVS_W'(shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rate_q <= FS_RESET;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				rate_q <= {quo_q[FS_W-2:0], fits};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= DVS_W'(reload) * DVS_W'(prescale);
			rem_q <= '0;
			quo_q <= DIVIDEND;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[FS_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign rate = rate_q;

endmodule

// ===== dv/tb_fft_spectrum_peak_finder.sv =====
// Self-checking testbench for fft_spectrum_peak_finder: streams FFT bins with random
// gaps and stalls and checks every result against an in-bench predictor.
// Depends on fspk_pkg and the fft_spectrum_peak_finder RTL.
module tb_fft_spectrum_peak_finder;
	import fspk_pkg::*;

	localparam int FFT_POINTS = 1024;
	localparam int LAST_BIN   = FFT_POINTS / 2 - 1;

	typedef struct {
		logic [MAG_W-1:0]  magnitude;
		logic [BIN_W-1:0]  bin_number;
		logic              frame_done;
		logic [BIN_W-1:0]  peak_bin;
		logic [FREQ_W-1:0] peak_freq;
	} bin_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [SMP_W-1:0] bin_real = '0;
	logic signed [SMP_W-1:0] bin_imag = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [MAG_W-1:0]        magnitude;
	logic [BIN_W-1:0]        bin_number;
	logic                    frame_done;
	logic [BIN_W-1:0]        peak_bin;
	logic [FREQ_W-1:0]       peak_freq;
	logic                    cfg_we = 1'b0;
	reg_idx_t                cfg_index = REG_TIMER_RELOAD;
	logic [CFG_W-1:0]        cfg_data = '0;

	// Predictor state.
	logic [RELOAD_W-1:0]   rate_reload = RELOAD_RESET;
	logic [PRESCALE_W-1:0] rate_prescale = PRESCALE_RESET;
	int unsigned           frame_pos = 1;
	pow_t                  best_power = '0;
	int unsigned           best_bin = 0;

	bin_result_t pending_results[$];
	int          mismatch_count = 0;
	bit          src_gaps_on = 1'b1;

	fft_spectrum_peak_finder #(
		.FFT_POINTS(FFT_POINTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bin_real(bin_real),
		.bin_imag(bin_imag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.magnitude(magnitude),
		.bin_number(bin_number),
		.frame_done(frame_done),
		.peak_bin(peak_bin),
		.peak_freq(peak_freq),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MAG_W-1:0] floor_root(input pow_t power);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 65536;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= power)
				lo = mid;
			else
				hi = mid;
		end
		return MAG_W'(lo);
	endfunction

	function automatic bin_result_t compute_bin_result(input logic signed [SMP_W-1:0] re,
			input logic signed [SMP_W-1:0] im);
		pow_t            power;
		longint unsigned rate_hz;
		longint unsigned div_reload;
		longint unsigned div_prescale;
		bin_result_t     r;
		power = pow_t'(longint'(re) * longint'(re) + longint'(im) * longint'(im));
		if (frame_pos == 1) begin
			best_power = '0;
			best_bin = 0;
		end
		// Strictly greater only, so the first of equal peaks is kept.
		if (power > best_power) begin
			best_power = power;
			best_bin = frame_pos;
		end
		r.magnitude = floor_root(power);
		r.bin_number = BIN_W'(frame_pos);
		r.frame_done = (frame_pos >= LAST_BIN);
		r.peak_bin = '0;
		r.peak_freq = '0;
		if (r.frame_done) begin
			div_reload = (rate_reload == 0) ? 1 : rate_reload;
			div_prescale = (rate_prescale == 0) ? 1 : rate_prescale;
			rate_hz = longint'(CLOCK_HZ) / div_reload / div_prescale;
			r.peak_bin = BIN_W'(best_bin);
			r.peak_freq = FREQ_W'(longint'(best_bin) * rate_hz / FFT_POINTS);
			frame_pos = 1;
		end else begin
			frame_pos++;
		end
		return r;
	endfunction

	function automatic int pick_gap(input bit gaps_on);
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [SMP_W-1:0] corner_sample();
		case ($urandom_range(0, 3))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] random_sample(input int mode);
		if (mode < 5)
			return SMP_W'($urandom());
		if (mode < 9)
			return SMP_W'(int'($urandom_range(0, 8)) - 4);
		return corner_sample();
	endfunction

	task automatic send_bin(input logic signed [SMP_W-1:0] re,
			input logic signed [SMP_W-1:0] im);
		int gap;
		gap = pick_gap(src_gaps_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bin_real <= re;
		bin_imag <= im;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(compute_bin_result(re, im));
	endtask

	task automatic send_random_bins(input int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				src_gaps_on = ($urandom_range(0, 4) != 0);
			mode = $urandom_range(0, 9);
			send_bin(random_sample(mode), random_sample(mode));
		end
	endtask

	// Lowers valid and holds the source until every expected result has arrived.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes both rate registers on two back-to-back cycles; call only while idle.
	task automatic write_rate(input logic [CFG_W-1:0] reload_data,
			input logic [CFG_W-1:0] prescale_data);
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMER_RELOAD;
		cfg_data <= reload_data;
		@(posedge clk);
		rate_reload = reload_data[RELOAD_W-1:0];
		cfg_index <= REG_TIMER_PRESCALE;
		cfg_data <= prescale_data;
		@(posedge clk);
		rate_prescale = prescale_data[PRESCALE_W-1:0];
		cfg_we <= 1'b0;
	endtask

	// Corner values; the second full-scale bin ties the first and must not win.
	task automatic test_extreme_bins();
		send_bin(16'sh0000, 16'sh0000);
		send_bin(16'sh8000, 16'sh8000);
		send_bin(16'sh7fff, 16'sh7fff);
		send_bin(16'sh8000, 16'sh7fff);
		send_bin(16'sh7fff, 16'sh8000);
		send_bin(16'sh0000, 16'sh8000);
		send_bin(16'sh8000, 16'sh0000);
		send_bin(16'sh0001, 16'sh0000);
		send_bin(16'sh0000, 16'shffff);
		send_bin(16'shffff, 16'shffff);
		send_bin(16'sh0003, 16'sh0004);
		send_bin(-16'sd4, 16'sh0003);
		send_bin(16'sh8000, 16'sh8000);
		send_bin(16'sh5555, -16'sd21846);
	endtask

	task automatic test_slowest_rate();
		wait_results_drained();
		write_rate(16'hffff, 16'hffff);
		send_random_bins(80);
	endtask

	task automatic test_frame_end_random_rate();
		wait_results_drained();
		write_rate(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 255)));
		send_random_bins(LAST_BIN - int'(frame_pos) + 1);
	endtask

	// An all-zero frame must report bin 0 even though the last frame peaked at full scale.
	task automatic test_zero_frame();
		wait_results_drained();
		write_rate(CFG_W'($urandom()), {8'hff, 8'($urandom_range(1, 255))});
		for (int i = 0; i < LAST_BIN; i++) begin
			if (i == LAST_BIN / 2)
				wait_results_drained();
			send_bin(16'sh0000, 16'sh0000);
		end
	endtask

	// Zero divisors act as one. Small bins ahead of a full-scale last bin put the
	// peak there, which gives the highest frequency.
	task automatic test_peak_on_last_bin();
		wait_results_drained();
		write_rate(16'h0000, 16'h0000);
		for (int i = 0; i < LAST_BIN - 1; i++)
			send_bin(random_sample(5), random_sample(5));
		send_bin(16'sh8000, 16'sh8000);
	endtask

	task automatic test_random_rates();
		logic [CFG_W-1:0] reload_data;
		logic [CFG_W-1:0] prescale_data;
		for (int k = 0; k < 4; k++) begin
			wait_results_drained();
			reload_data = (k == 0) ? 16'h0001 : CFG_W'($urandom());
			prescale_data = (k == 0) ? 16'h0001 : CFG_W'($urandom());
			write_rate(reload_data, prescale_data);
			send_random_bins(45);
		end
	endtask

	initial begin : sink_ready
		int run_len;
		int stall_len;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = pick_gap(1'b1);
			if (stall_len > 0) begin
				out_ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		bin_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expectation pending: bin_number %0d", bin_number);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, got %0d", want.magnitude, magnitude);
					mismatch_count++;
				end
				if (bin_number !== want.bin_number) begin
					$error("bin_number: expected %0d, got %0d", want.bin_number, bin_number);
					mismatch_count++;
				end
				if (frame_done !== want.frame_done) begin
					$error("frame_done: expected %0d, got %0d", want.frame_done, frame_done);
					mismatch_count++;
				end
				if (peak_bin !== want.peak_bin) begin
					$error("peak_bin: expected %0d, got %0d", want.peak_bin, peak_bin);
					mismatch_count++;
				end
				if (peak_freq !== want.peak_freq) begin
					$error("peak_freq: expected %0d, got %0d", want.peak_freq, peak_freq);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_bins();
		test_slowest_rate();
		test_frame_end_random_rate();
		test_zero_frame();
		test_peak_on_last_bin();
		test_random_rates();
		wait_results_drained();
		repeat (30) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#6000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fspk_pkg.sv
sv/fspk_sqrt_cell.sv
sv/fspk_rate_div.sv
sv/fft_spectrum_peak_finder.sv
dv/tb_fft_spectrum_peak_finder.sv
